@@ hw/rtl/rwr_pkg.sv @@
// ----------------------------------------------------------------------------
// rwr_pkg: shared types and constants for the running window RMS block
// Register map, field widths, reset values and the configuration struct.
// ----------------------------------------------------------------------------
package rwr_pkg;

  // default sizes handed to the top level
  localparam int WINDOW_MAX_DEF  = 64;
  localparam int SAMPLE_BITS_DEF = 16;

  // configuration register width and APB port sizes
  localparam int CFG_W   = 7;
  localparam int APB_DW  = 32;
  localparam int APB_AW  = 4;

  // register indexes (byte address is 4 * index)
  localparam logic [1:0] REG_WINDOW_LEN   = 2'd0;
  localparam logic [1:0] REG_LEADING_MODE = 2'd1;
  localparam logic [1:0] REG_MIN_COUNT    = 2'd2;

  // register reset values
  localparam logic [CFG_W-1:0] WINDOW_LEN_RST = 7'd8;
  localparam logic             LEADING_RST    = 1'b0;
  localparam logic [CFG_W-1:0] MIN_COUNT_RST  = 7'd2;
  localparam logic [CFG_W-1:0] MIN_COUNT_LOW  = 7'd2;

  // result format: unsigned Q16.8, root of a 48-bit radicand
  localparam int RMS_W      = 24;
  localparam int RAD_W      = 2 * RMS_W;
  localparam int SQRT_REM_W = RMS_W + 2;
  localparam int FRAC_SHIFT = 16;
  localparam logic [RMS_W-1:0] RMS_MAX = '1;

  typedef struct packed {
    logic [CFG_W-1:0] window_len;
    logic             leading_mode;
    logic [CFG_W-1:0] min_count;
  } cfg_t;

endpackage

@@ hw/rtl/rwr_in_if.sv @@
// ----------------------------------------------------------------------------
// rwr_in_if: sample channel
// Valid/ready channel carrying one sample with its missing and last flags.
// ----------------------------------------------------------------------------
interface rwr_in_if #(
  parameter int SAMPLE_BITS = rwr_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          sample_missing;
  logic                          stream_last;

  modport source (output valid, sample, sample_missing, stream_last, input ready);
  modport sink   (input valid, sample, sample_missing, stream_last, output ready);
endinterface

@@ hw/rtl/rwr_out_if.sv @@
// ----------------------------------------------------------------------------
// rwr_out_if: result channel
// Valid/ready channel carrying one RMS result with its status flags.
// ----------------------------------------------------------------------------
interface rwr_out_if;
  logic                       valid;
  logic                       ready;
  logic [rwr_pkg::RMS_W-1:0]  rms_value;
  logic                       rms_defined;
  logic                       result_last;
  logic                       short_stream;

  modport source (output valid, rms_value, rms_defined, result_last, short_stream,
                  input ready);
  modport sink   (input valid, rms_value, rms_defined, result_last, short_stream,
                  output ready);
endinterface

@@ hw/rtl/rwr_cfg.sv @@
// ----------------------------------------------------------------------------
// rwr_cfg: configuration registers
// APB-style register file; any write to a known register restarts the stream.
// ----------------------------------------------------------------------------
module rwr_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [rwr_pkg::APB_AW-1:0]   cfg_paddr,
  input  logic [rwr_pkg::APB_DW-1:0]   cfg_pwdata,
  output logic [rwr_pkg::APB_DW-1:0]   cfg_prdata,
  output logic                         cfg_pready,
  output rwr_pkg::cfg_t                cfg,
  output logic                         restart
);

  rwr_pkg::cfg_t cfg_r;
  logic          wr_en;
  logic [1:0]    reg_idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite;
  assign reg_idx    = cfg_paddr[3:2];
  assign cfg        = cfg_r;

  // flag a write to a known register
  always_comb begin
    case (reg_idx)
      rwr_pkg::REG_WINDOW_LEN,
      rwr_pkg::REG_LEADING_MODE,
      rwr_pkg::REG_MIN_COUNT: restart = wr_en;
      default:                restart = 1'b0;
    endcase
  end

  // hold the registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.window_len   <= rwr_pkg::WINDOW_LEN_RST;
      cfg_r.leading_mode <= rwr_pkg::LEADING_RST;
      cfg_r.min_count    <= rwr_pkg::MIN_COUNT_RST;
    end else if (wr_en) begin
      case (reg_idx)
        rwr_pkg::REG_WINDOW_LEN:   cfg_r.window_len   <= cfg_pwdata[rwr_pkg::CFG_W-1:0];
        rwr_pkg::REG_LEADING_MODE: cfg_r.leading_mode <= cfg_pwdata[0];
        rwr_pkg::REG_MIN_COUNT:    cfg_r.min_count    <= cfg_pwdata[rwr_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (reg_idx)
      rwr_pkg::REG_WINDOW_LEN:   cfg_prdata = rwr_pkg::APB_DW'(cfg_r.window_len);
      rwr_pkg::REG_LEADING_MODE: cfg_prdata = rwr_pkg::APB_DW'(cfg_r.leading_mode);
      rwr_pkg::REG_MIN_COUNT:    cfg_prdata = rwr_pkg::APB_DW'(cfg_r.min_count);
      default:                   cfg_prdata = '0;
    endcase
  end

endmodule

@@ hw/rtl/rwr_sq.sv @@
// ----------------------------------------------------------------------------
// rwr_sq: bit-serial squarer
// Shift-and-add square of a magnitude, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module rwr_sq #(
  parameter int SAMPLE_BITS = rwr_pkg::SAMPLE_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [SAMPLE_BITS-1:0]     mag,
  output logic                       done,
  output logic [2*SAMPLE_BITS-1:0]   sq
);

  localparam int SQ_W = 2 * SAMPLE_BITS;
  localparam int CW   = $clog2(SAMPLE_BITS + 1);

  logic [SQ_W-1:0]        mcand_r;
  logic [SAMPLE_BITS-1:0] mplier_r;
  logic [SQ_W-1:0]        acc_r;
  logic [CW-1:0]          cnt_r;
  logic                   busy_r;
  logic                   done_r;

  assign done = done_r;
  assign sq   = acc_r;

  // step control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(SAMPLE_BITS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // add the shifted multiplicand for each set multiplier bit
  always_ff @(posedge clk) begin
    if (start) begin
      mcand_r  <= SQ_W'(mag);
      mplier_r <= mag;
      acc_r    <= '0;
    end else if (busy_r) begin
      if (mplier_r[0]) begin
        acc_r <= acc_r + mcand_r;
      end
      mcand_r  <= mcand_r << 1;
      mplier_r <= mplier_r >> 1;
    end
  end

endmodule

@@ hw/rtl/rwr_div.sv @@
// ----------------------------------------------------------------------------
// rwr_div: bit-serial restoring divider
// Shifts the dividend through a narrow remainder, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rwr_div #(
  parameter int DIV_W = 54,
  parameter int DV_W  = 7
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DV_W-1:0]  divisor,
  output logic             done,
  output logic [DIV_W-1:0] quot
);

  localparam int CW = $clog2(DIV_W + 1);

  logic [DIV_W-1:0] dq_r;
  logic [DV_W-1:0]  rem_r;
  logic [DV_W-1:0]  dvs_r;
  logic [CW-1:0]    cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DV_W:0]    trial;
  logic             fits;

  assign done  = done_r;
  assign quot  = dq_r;
  assign trial = {rem_r, dq_r[DIV_W-1]};
  assign fits  = trial >= {1'b0, dvs_r};

  // step control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DIV_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // shift in one dividend bit, subtract when the divisor fits
  always_ff @(posedge clk) begin
    if (start) begin
      dq_r  <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= fits ? DV_W'(trial - {1'b0, dvs_r}) : DV_W'(trial);
      dq_r  <= {dq_r[DIV_W-2:0], fits};
    end
  end

endmodule

@@ hw/rtl/rwr_sqrt.sv @@
// ----------------------------------------------------------------------------
// rwr_sqrt: digit-serial integer square root
// Two radicand bits per cycle, one root bit per cycle, floor result.
// ----------------------------------------------------------------------------
module rwr_sqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [rwr_pkg::RAD_W-1:0]   rad,
  output logic                        done,
  output logic [rwr_pkg::RMS_W-1:0]   root
);

  localparam int RW = rwr_pkg::RMS_W;
  localparam int AW = rwr_pkg::RAD_W;
  localparam int EW = rwr_pkg::SQRT_REM_W;
  localparam int CW = $clog2(RW + 1);

  logic [AW-1:0] rad_r;
  logic [RW-1:0] root_r;
  logic [EW-1:0] rem_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [EW-1:0] rem_sh;
  logic [EW-1:0] trial;
  logic          fits;

  assign done   = done_r;
  assign root   = root_r;
  assign rem_sh = {rem_r[EW-3:0], rad_r[AW-1:AW-2]};
  assign trial  = {root_r, 2'b01};
  assign fits   = rem_sh >= trial;

  // step control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(RW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // bring down two bits, decide one root bit
  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= rad;
      root_r <= '0;
      rem_r  <= '0;
    end else if (busy_r) begin
      rad_r  <= rad_r << 2;
      rem_r  <= fits ? (rem_sh - trial) : rem_sh;
      root_r <= {root_r[RW-2:0], fits};
    end
  end

endmodule

@@ hw/rtl/running_window_rms_top.sv @@
// ----------------------------------------------------------------------------
// running_window_rms_top: sliding-window RMS with zero mean
// Delay line of squares, running sum and count, serial divide and root.
// ----------------------------------------------------------------------------
// Usage:
//   in_s carries one sample per item (value, missing flag, last-of-stream).
//   out_m carries RMS results in unsigned Q16.8 with defined/last/short flags.
//   cfg_* is an APB-style port: window_len at 0x0, leading_mode at 0x4,
//   min_count at 0x8; a write restarts the stream state. Write only when idle.
// Processing:
//   One item at a time. Each item is squared by the bit-serial squarer and
//   then updates the sum and count. Each defined result goes through the
//   bit-serial divider (DIV_W = 2*SAMPLE_BITS + log2(window) + 16, 54 by
//   default) and the 24-step root unit; an undefined result skips both.
//   Trailing mode gives one result per item; leading mode gives none until the
//   window fills, then one, and the last item flushes one per sample held.
// Reset and stall:
//   rst_n clears the stream state and loads the register defaults; the delay
//   line memory is not cleared, only entries written in the current stream are
//   read. A result waits in the output register while out_m.ready is low, and
//   the block holds off the next result until it is taken.
// ----------------------------------------------------------------------------
module running_window_rms_top #(
  parameter int WINDOW_MAX  = rwr_pkg::WINDOW_MAX_DEF,
  parameter int SAMPLE_BITS = rwr_pkg::SAMPLE_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  rwr_in_if.sink                      in_s,
  rwr_out_if.source                   out_m,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [rwr_pkg::APB_AW-1:0]  cfg_paddr,
  input  logic [rwr_pkg::APB_DW-1:0]  cfg_pwdata,
  output logic [rwr_pkg::APB_DW-1:0]  cfg_prdata,
  output logic                        cfg_pready
);

  localparam int CFG_W  = rwr_pkg::CFG_W;
  localparam int RMS_W  = rwr_pkg::RMS_W;
  localparam int RAD_W  = rwr_pkg::RAD_W;
  localparam int SQ_W   = 2 * SAMPLE_BITS;
  localparam int AW     = $clog2(WINDOW_MAX);
  localparam int DEPTH  = 2 ** AW;
  localparam int CNT_W  = $clog2(WINDOW_MAX + 2);
  localparam int SUM_W  = SQ_W + AW;
  localparam int DIV_W  = (SUM_W + rwr_pkg::FRAC_SHIFT > RAD_W + 1) ?
                          SUM_W + rwr_pkg::FRAC_SHIFT : RAD_W + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_SQ, S_UPD, S_FL, S_EMIT, S_DIV, S_ROOT, S_OUT, S_POST
  } state_t;

  typedef struct packed {
    logic            miss;
    logic [SQ_W-1:0] sq;
  } entry_t;

  state_t             state_r;
  rwr_pkg::cfg_t      cfg;
  logic               restart;

  // stream state
  logic [SUM_W-1:0]   sum_r;
  logic [CNT_W-1:0]   count_r;
  logic [CNT_W-1:0]   seen_r;
  logic [CNT_W-1:0]   flush_r;
  logic [AW-1:0]      wp_r;
  logic [AW-1:0]      rd_addr_r;

  // item and result context
  logic               item_miss_r;
  logic               item_last_r;
  logic               item_shrt_r;
  logic               flush_mode_r;
  logic               em_last_r;
  logic               em_shrt_r;
  logic [RMS_W-1:0]   res_val_r;
  logic               res_def_r;

  // output register
  logic               out_valid_r;
  logic [RMS_W-1:0]   out_value_r;
  logic               out_def_r;
  logic               out_last_r;
  logic               out_shrt_r;

  // delay line of squares
  entry_t             mem [DEPTH];
  entry_t             mem_q_r;
  logic               mem_we;
  entry_t             mem_wd;

  // effective window and minimum
  logic [CFG_W-1:0]   w_sel;
  logic [CNT_W-1:0]   w_eff;
  logic [CFG_W-1:0]   minc;
  logic               defined;

  // arithmetic units
  logic [SAMPLE_BITS-1:0] raw;
  logic [SAMPLE_BITS-1:0] mag;
  logic                   sq_start;
  logic                   sq_done;
  logic [SQ_W-1:0]        sq;
  logic                   div_start;
  logic                   div_done;
  logic [DIV_W-1:0]       quot;
  logic                   rt_start;
  logic                   rt_done;
  logic [RMS_W-1:0]       root;

  // update terms
  logic               drop_tr;
  logic [SUM_W-1:0]   add_term;
  logic [SUM_W-1:0]   sub_term;
  logic [CNT_W-1:0]   n_seen;
  logic [CNT_W-1:0]   seen_nxt;
  logic [CNT_W-1:0]   fl_nxt;
  logic               in_acc;

  rwr_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg),
    .restart     (restart)
  );

  rwr_sq #(.SAMPLE_BITS(SAMPLE_BITS)) u_sq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .mag   (mag),
    .done  (sq_done),
    .sq    (sq)
  );

  rwr_div #(.DIV_W(DIV_W), .DV_W(CNT_W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (DIV_W'(sum_r) << rwr_pkg::FRAC_SHIFT),
    .divisor  (count_r),
    .done     (div_done),
    .quot     (quot)
  );

  rwr_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (rt_start),
    .rad   (quot[RAD_W-1:0]),
    .done  (rt_done),
    .root  (root)
  );

  // clamp the window and the minimum count
  always_comb begin
    if (cfg.window_len == '0) begin
      w_sel = CFG_W'(1);
    end else if (cfg.window_len > CFG_W'(WINDOW_MAX)) begin
      w_sel = CFG_W'(WINDOW_MAX);
    end else begin
      w_sel = cfg.window_len;
    end
    minc = (cfg.min_count < rwr_pkg::MIN_COUNT_LOW) ? rwr_pkg::MIN_COUNT_LOW
                                                    : cfg.min_count;
  end

  assign w_eff   = CNT_W'(w_sel);
  assign defined = CFG_W'(count_r) >= minc;

  // sample magnitude for the squarer
  assign raw      = in_s.sample;
  assign mag      = raw[SAMPLE_BITS-1] ? SAMPLE_BITS'(~raw + 1'b1) : raw;
  assign in_acc   = in_s.valid & in_s.ready;
  assign sq_start = in_acc;
  assign in_s.ready = (state_r == S_IDLE) && !restart;

  // unit starts
  assign div_start = (state_r == S_EMIT) && defined;
  assign rt_start  = (state_r == S_DIV) && div_done && (quot[DIV_W-1:RAD_W] == '0);

  // sum and count terms of the update step
  assign drop_tr  = !cfg.leading_mode && (seen_r >= w_eff);
  assign add_term = item_miss_r ? '0 : SUM_W'(sq);
  assign sub_term = (drop_tr && !mem_q_r.miss) ? SUM_W'(mem_q_r.sq) : '0;
  assign n_seen   = seen_r + 1'b1;
  assign seen_nxt = (n_seen > w_eff) ? w_eff : n_seen;
  assign fl_nxt   = flush_r - 1'b1;

  assign mem_we      = (state_r == S_UPD);
  assign mem_wd.miss = item_miss_r;
  assign mem_wd.sq   = item_miss_r ? '0 : sq;

  // delay line memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wp_r] <= mem_wd;
    end
    mem_q_r <= mem[rd_addr_r];
  end

  // sequencer, stream state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      sum_r        <= '0;
      count_r      <= '0;
      seen_r       <= '0;
      flush_r      <= '0;
      wp_r         <= '0;
      rd_addr_r    <= '0;
      flush_mode_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      // drop the taken result unless a new one is loaded this cycle
      if (out_valid_r && out_m.ready && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (restart) begin
            sum_r   <= '0;
            count_r <= '0;
            seen_r  <= '0;
            flush_r <= '0;
          end else if (in_acc) begin
            item_miss_r <= in_s.sample_missing;
            item_last_r <= in_s.stream_last;
            rd_addr_r   <= AW'(wp_r - AW'(w_eff));
            state_r     <= S_SQ;
          end
        end
        S_SQ: begin
          if (sq_done) begin
            state_r <= S_UPD;
          end
        end
        S_UPD: begin
          // drop the oldest sample in trailing mode once the window is full, add the new one
          sum_r   <= sum_r + add_term - sub_term;
          count_r <= count_r + CNT_W'(!item_miss_r)
                     - CNT_W'(drop_tr && !mem_q_r.miss);
          wp_r    <= wp_r + 1'b1;
          seen_r  <= seen_nxt;
          item_shrt_r  <= n_seen < w_eff;
          flush_mode_r <= 1'b0;
          if (!cfg.leading_mode) begin
            em_last_r <= item_last_r;
            em_shrt_r <= item_last_r && (n_seen < w_eff);
            state_r   <= S_EMIT;
          end else if (item_last_r) begin
            flush_r      <= seen_nxt;
            flush_mode_r <= 1'b1;
            state_r      <= S_FL;
          end else if (seen_nxt >= w_eff) begin
            em_last_r <= 1'b0;
            em_shrt_r <= 1'b0;
            rd_addr_r <= AW'(wp_r + 1'b1 - AW'(w_eff));
            state_r   <= S_EMIT;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_FL: begin
          // next tail window; its oldest entry is dropped after the result
          flush_r   <= fl_nxt;
          em_last_r <= (fl_nxt == '0);
          em_shrt_r <= item_shrt_r && (fl_nxt == '0);
          rd_addr_r <= AW'(wp_r - 1'b1 - AW'(fl_nxt));
          state_r   <= S_EMIT;
        end
        S_EMIT: begin
          if (defined) begin
            state_r <= S_DIV;
          end else begin
            res_val_r <= '0;
            res_def_r <= 1'b0;
            state_r   <= S_OUT;
          end
        end
        S_DIV: begin
          if (div_done) begin
            if (quot[DIV_W-1:RAD_W] != '0) begin
              res_val_r <= rwr_pkg::RMS_MAX;
              res_def_r <= 1'b1;
              state_r   <= S_OUT;
            end else begin
              state_r <= S_ROOT;
            end
          end
        end
        S_ROOT: begin
          if (rt_done) begin
            res_val_r <= root;
            res_def_r <= 1'b1;
            state_r   <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_m.ready) begin
            out_valid_r <= 1'b1;
            out_value_r <= res_val_r;
            out_def_r   <= res_def_r;
            out_last_r  <= em_last_r;
            out_shrt_r  <= em_shrt_r;
            state_r     <= S_POST;
          end
        end
        S_POST: begin
          if (!cfg.leading_mode) begin
            if (item_last_r) begin
              sum_r   <= '0;
              count_r <= '0;
              seen_r  <= '0;
              flush_r <= '0;
            end
            state_r <= S_IDLE;
          end else if (flush_mode_r && (flush_r == '0)) begin
            // end of stream: clear the stream state
            sum_r   <= '0;
            count_r <= '0;
            seen_r  <= '0;
            flush_r <= '0;
            state_r <= S_IDLE;
          end else begin
            // drop the window's first entry
            if (!mem_q_r.miss) begin
              sum_r   <= sum_r - SUM_W'(mem_q_r.sq);
              count_r <= count_r - 1'b1;
            end
            state_r <= flush_mode_r ? S_FL : S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_m.valid        = out_valid_r;
  assign out_m.rms_value    = out_value_r;
  assign out_m.rms_defined  = out_def_r;
  assign out_m.result_last  = out_last_r;
  assign out_m.short_stream = out_shrt_r;

endmodule

@@ sim/rwr_checker.sv @@
// ----------------------------------------------------------------------------
// rwr_checker: result predictor and scoreboard for the running window RMS
// Watches register writes and accepted sample items, predicts the RMS results
// that each item causes and compares every accepted result field by field
// against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module rwr_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  rwr_in_if                          in_mon,
  rwr_out_if                         out_mon,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic                       cfg_pready,
  input  logic [rwr_pkg::APB_AW-1:0] cfg_paddr,
  input  logic [rwr_pkg::APB_DW-1:0] cfg_pwdata,
  output int                         err_count,
  output int                         rms_pending
);

  localparam int DEPTH = rwr_pkg::WINDOW_MAX_DEF;
  localparam int SB    = rwr_pkg::SAMPLE_BITS_DEF;

  typedef struct {
    logic [rwr_pkg::RMS_W-1:0] rms;
    bit                        defined;
    bit                        last;
    bit                        short_flag;
  } rms_result_t;

  rms_result_t      rms_expected[$];

  // model copy of registers and stream state
  logic [rwr_pkg::CFG_W-1:0] win_reg;
  logic                      lead_reg;
  logic [rwr_pkg::CFG_W-1:0] minc_reg;
  logic signed [SB-1:0]      line_val [DEPTH];
  bit                        line_miss [DEPTH];
  logic [63:0]               sq_sum;
  int                        present;
  int                        seen;

  function automatic logic [63:0] square(logic signed [SB-1:0] v);
    logic [63:0] m;
    m = (v < 0) ? 64'(-64'(v)) : 64'(v);
    return m * m;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] rad);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > rad) b = b >> 2;
    while (b != 0) begin
      if (rad >= res + b) begin
        rad = rad - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  task automatic clear_stream();
    for (int k = 0; k < DEPTH; k++) begin
      line_val[k] = '0;
      line_miss[k] = 1'b1;
    end
    sq_sum = 0;
    present = 0;
    seen = 0;
  endtask

  task automatic drop_entry(int k);
    if (k < DEPTH && !line_miss[k]) begin
      sq_sum = sq_sum - square(line_val[k]);
      if (present > 0) present--;
    end
  endtask

  // predict one result from the current sum and count
  task automatic predict_rms(bit last, bit shrt);
    rms_result_t r;
    int          minc;
    logic [63:0] q;
    logic [63:0] rem;
    logic [63:0] root;
    minc = (minc_reg < 2) ? 2 : int'(minc_reg);
    r.rms = '0;
    r.defined = (present >= minc);
    if (r.defined) begin
      q = sq_sum / present;
      rem = sq_sum % present;
      if (q >= (64'd1 << 32)) begin
        r.rms = rwr_pkg::RMS_MAX;
      end else begin
        root = int_sqrt((q << rwr_pkg::FRAC_SHIFT) +
                        ((rem << rwr_pkg::FRAC_SHIFT) / present));
        r.rms = (root > 64'(rwr_pkg::RMS_MAX)) ? rwr_pkg::RMS_MAX
                                               : root[rwr_pkg::RMS_W-1:0];
      end
    end
    r.last = last;
    r.short_flag = last && shrt;
    rms_expected.push_back(r);
  endtask

  task automatic take_sample(logic signed [SB-1:0] v, bit miss, bit last);
    int w;
    int n;
    bit shrt;
    int flush;
    w = (win_reg < 1) ? 1 : (win_reg > DEPTH) ? DEPTH : int'(win_reg);
    if (!lead_reg && seen >= w) drop_entry(w - 1);
    for (int k = DEPTH - 1; k > 0; k--) begin
      line_val[k] = line_val[k-1];
      line_miss[k] = line_miss[k-1];
    end
    line_val[0] = miss ? '0 : v;
    line_miss[0] = miss;
    if (!miss) begin
      sq_sum = sq_sum + square(v);
      present++;
    end
    n = seen + 1;
    shrt = (n < w);
    seen = (n > w) ? w : n;
    if (!lead_reg) begin
      predict_rms(last, shrt);
    end else if (last) begin
      // flush the shrinking tail windows
      flush = seen;
      while (flush > 0) begin
        flush--;
        predict_rms(flush == 0, shrt);
        drop_entry(flush);
      end
    end else if (seen >= w) begin
      predict_rms(1'b0, 1'b0);
      drop_entry(w - 1);
    end
    if (last) clear_stream();
  endtask

  always @(posedge clk) begin
    rms_result_t e;
    if (!rst_n) begin
      win_reg = rwr_pkg::WINDOW_LEN_RST;
      lead_reg = rwr_pkg::LEADING_RST;
      minc_reg = rwr_pkg::MIN_COUNT_RST;
      clear_stream();
      rms_expected.delete();
      err_count <= 0;
      rms_pending <= 0;
    end else begin
      // track register writes; a write to a known register restarts the stream
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[3:2])
          rwr_pkg::REG_WINDOW_LEN: begin
            win_reg = cfg_pwdata[rwr_pkg::CFG_W-1:0];
            clear_stream();
          end
          rwr_pkg::REG_LEADING_MODE: begin
            lead_reg = cfg_pwdata[0];
            clear_stream();
          end
          rwr_pkg::REG_MIN_COUNT: begin
            minc_reg = cfg_pwdata[rwr_pkg::CFG_W-1:0];
            clear_stream();
          end
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready)
        take_sample(in_mon.sample, in_mon.sample_missing, in_mon.stream_last);
      // compare each accepted result with the oldest prediction
      if (out_mon.valid && out_mon.ready) begin
        if (rms_expected.size() == 0) begin
          $display("%0t: unexpected result rms=%0d def=%0b last=%0b short=%0b", $time,
                   out_mon.rms_value, out_mon.rms_defined, out_mon.result_last,
                   out_mon.short_stream);
          err_count <= err_count + 1;
        end else begin
          e = rms_expected.pop_front();
          if (out_mon.rms_value !== e.rms || out_mon.rms_defined !== e.defined ||
              out_mon.result_last !== e.last || out_mon.short_stream !== e.short_flag) begin
            $display("%0t: mismatch expected rms=%0d def=%0b last=%0b short=%0b", $time,
                     e.rms, e.defined, e.last, e.short_flag);
            $display("%0t:          actual   rms=%0d def=%0b last=%0b short=%0b", $time,
                     out_mon.rms_value, out_mon.rms_defined, out_mon.result_last,
                     out_mon.short_stream);
            err_count <= err_count + 1;
          end
        end
      end
      rms_pending <= rms_expected.size();
    end
  end

endmodule

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: testbench for the running window RMS block
// Drives directed and random sample streams over several register settings,
// with bursty input and a stalling receiver, and reports the checker verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

  localparam int  SETTLE = 400;
  localparam longint CYCLE_LIMIT = 3000000;

  logic                       clk;
  logic                       rst_n;
  logic                       cfg_psel;
  logic                       cfg_penable;
  logic                       cfg_pwrite;
  logic [rwr_pkg::APB_AW-1:0] cfg_paddr;
  logic [rwr_pkg::APB_DW-1:0] cfg_pwdata;
  logic [rwr_pkg::APB_DW-1:0] cfg_prdata;
  logic                       cfg_pready;
  int                         err_count;
  int                         rms_pending;
  int                         burst_left;
  int                         stall_style;
  longint                     cycles;

  rwr_in_if  in_ch ();
  rwr_out_if out_ch ();

  running_window_rms_top DUT (
    .clk(clk), .rst_n(rst_n), .in_s(in_ch.sink), .out_m(out_ch.source),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  rwr_checker u_checker (
    .clk(clk), .rst_n(rst_n), .in_mon(in_ch), .out_mon(out_ch),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_pready(cfg_pready), .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata),
    .err_count(err_count), .rms_pending(rms_pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // receiver stall pattern, style changes per phase
  always @(posedge clk) begin
    case (stall_style)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= ($urandom_range(0, 3) != 0);
      2: out_ch.ready <= (cycles % 64) > 40;
      default: out_ch.ready <= ($urandom_range(0, 1) == 0);
    endcase
  end

  // run watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic cfg_write(logic [1:0] idx, int unsigned val);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= rwr_pkg::APB_AW'(idx) << 2;
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // hold valid and wait for the item to be taken; gaps between bursts
  task automatic send_item(logic [15:0] s, bit miss, bit last);
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 10);
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.sample <= s;
    in_ch.sample_missing <= miss;
    in_ch.stream_last <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (rms_pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_regs(int unsigned w, int unsigned lead, int unsigned minc);
    drain();
    cfg_write(rwr_pkg::REG_WINDOW_LEN, w);
    cfg_write(rwr_pkg::REG_LEADING_MODE, lead);
    cfg_write(rwr_pkg::REG_MIN_COUNT, minc);
    stall_style = $urandom_range(0, 3);
  endtask

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'(signed'($urandom_range(0, 20)) - 10);
      default: return 16'($urandom);
    endcase
  endfunction

  // one stream of random content, closed by a last item
  task automatic rand_stream(int len);
    for (int k = 0; k < len; k++)
      send_item(rand_sample(), $urandom_range(0, 6) == 0, k == len - 1);
  endtask

  initial begin
    int w;
    int sent;
    rst_n = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.sample = '0;
    in_ch.sample_missing = 1'b0;
    in_ch.stream_last = 1'b0;
    out_ch.ready = 1'b0;
    stall_style = 0;
    burst_left = 0;
    cycles = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: extremes, missing samples, missing last sample
    send_item(16'h7fff, 0, 0);
    send_item(16'h8000, 0, 0);
    send_item(16'h0000, 0, 0);
    send_item(16'hffff, 1, 0);
    send_item(16'h0001, 0, 0);
    send_item(16'hffff, 1, 1);
    // leading mode, full stream and short stream
    set_regs(4, 1, 2);
    for (int k = 0; k < 6; k++) send_item(16'(k * 1000 - 2500), 0, k == 5);
    send_item(16'h8000, 0, 0);
    send_item(16'h7fff, 0, 1);
    // trailing short stream, window of zero, oversized window
    set_regs(5, 0, 2);
    send_item(16'h1234, 0, 0);
    send_item(16'h8001, 0, 1);
    set_regs(0, 0, 0);
    send_item(16'h4000, 0, 0);
    send_item(16'hc000, 0, 1);
    set_regs(100, 1, 1);
    send_item(16'h0100, 0, 0);
    send_item(16'h0200, 1, 1);
    // minimum above the window
    set_regs(3, 0, 70);
    send_item(16'h7fff, 0, 0);
    send_item(16'h7fff, 0, 0);
    send_item(16'h7fff, 0, 1);

    // random settings and streams
    sent = 0;
    while (sent < 180) begin
      case ($urandom_range(0, 5))
        0: w = 64;
        1: w = 1;
        2: w = $urandom_range(0, 127);
        default: w = $urandom_range(2, 12);
      endcase
      set_regs(w, $urandom_range(0, 1), $urandom_range(0, 4) == 0 ?
               $urandom_range(0, 127) : $urandom_range(0, 4));
      repeat ($urandom_range(1, 3)) begin
        w = $urandom_range(1, 24);
        rand_stream(w);
        sent += w;
      end
    end

    drain();
    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
